@@ rtl/lcdseq_pkg.sv @@
// Shared types, codes and the power-up table for the character LCD nibble sequencer.
package lcdseq_pkg;

  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_BYTE   = 3'd1,
    CMD_CHAR   = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_HOME   = 3'd4,
    CMD_CURSOR = 3'd5
  } cmd_code_t;

  typedef enum logic [2:0] {
    WAIT_SETTLE,
    WAIT_LONG_CMD,
    WAIT_POWERUP,
    WAIT_WAKE1,
    WAIT_WAKE2
  } wait_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_HI,
    ST_LO
  } state_t;

  typedef enum logic [1:0] {
    SRC_INIT,
    SRC_HI,
    SRC_LO
  } src_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_INIT,
    KIND_BYTE
  } kind_t;

  localparam int unsigned StepW = 4;
  localparam logic [StepW-1:0] INIT_LAST_STEP = 4'd12;

  localparam logic [7:0] ROW1_BASE   = 8'h80;
  localparam logic [7:0] ROW2_BASE   = 8'hC0;
  localparam logic [7:0] BYTE_CLEAR  = 8'h01;
  localparam logic [7:0] BYTE_HOME   = 8'h02;
  localparam logic [1:0] ROW_FIRST   = 2'd1;
  localparam logic [1:0] ROW_SECOND  = 2'd2;

  typedef struct packed {
    logic             capture;
    logic             load;
    src_t             src;
    logic [StepW-1:0] step;
    logic             last;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  slot_free;
  } dp_status_t;

  typedef struct packed {
    logic       strobe;
    logic [3:0] nibble;
    wait_code_t wait_code;
  } init_entry_t;

  function automatic logic [15:0] wait_value(wait_code_t code);
    logic [15:0] v;
    unique case (code)
      WAIT_SETTLE:   v = 16'd100;
      WAIT_LONG_CMD: v = 16'd2100;
      WAIT_POWERUP:  v = 16'd40000;
      WAIT_WAKE1:    v = 16'd5100;
      WAIT_WAKE2:    v = 16'd250;
      default:       v = 16'd100;
    endcase
    return v;
  endfunction

  // Power-up wait, wake-up nibbles, then 0x28, 0x0E, 0x01, 0x06.
  function automatic init_entry_t init_entry(logic [StepW-1:0] step);
    init_entry_t e;
    e = '{strobe: 1'b1, nibble: 4'h0, wait_code: WAIT_SETTLE};
    unique case (step)
      4'd0:    e = '{strobe: 1'b0, nibble: 4'h0, wait_code: WAIT_POWERUP};
      4'd1:    e.nibble = 4'h3;
      4'd2:    e.nibble = 4'h3;
      4'd3:    e.nibble = 4'h3;
      4'd4:    e.nibble = 4'h2;
      4'd5:    e.nibble = 4'h2;
      4'd6:    e.nibble = 4'h8;
      4'd7:    e.nibble = 4'h0;
      4'd8:    e.nibble = 4'hE;
      4'd9:    e.nibble = 4'h0;
      4'd10:   e.nibble = 4'h1;
      4'd11:   e.nibble = 4'h0;
      4'd12:   e.nibble = 4'h6;
      default: e.nibble = 4'h0;
    endcase
    if (step == 4'd1) e.wait_code = WAIT_WAKE1;
    if (step == 4'd2) e.wait_code = WAIT_WAKE2;
    if (step == 4'd10) e.wait_code = WAIT_LONG_CMD;
    return e;
  endfunction

endpackage

@@ rtl/lcdseq_dp.sv @@
// Datapath: request decode, captured byte, and the result register.
module lcdseq_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [2:0]            command,
  input  logic [7:0]            value,
  input  logic [1:0]            row,
  input  logic [7:0]            column,
  input  lcdseq_pkg::ctrl_cmd_t cmd,
  output lcdseq_pkg::dp_status_t st,
  input  logic                  res_ready,
  output logic                  res_valid,
  output logic                  strobe_res,
  output logic                  reg_select,
  output logic [3:0]            nibble,
  output logic [15:0]           wait_us,
  output logic                  last
);

  logic [7:0] byte_q, byte_next;
  logic       rs_q, rs_next;
  logic       long_q, long_next;
  logic [7:0] addr;

  logic                    strobe_next, rsel_next;
  logic [3:0]              nibble_next;
  logic [15:0]             wait_next;
  lcdseq_pkg::init_entry_t ent;

  assign addr = column - 8'd1;

  always_comb begin
    byte_next    = value;
    rs_next      = 1'b0;
    long_next    = 1'b0;
    st.kind      = lcdseq_pkg::KIND_NONE;
    st.slot_free = !res_valid || res_ready;
    unique case (lcdseq_pkg::cmd_code_t'(command))
      lcdseq_pkg::CMD_INIT: begin
        st.kind = lcdseq_pkg::KIND_INIT;
      end
      lcdseq_pkg::CMD_BYTE: begin
        st.kind = lcdseq_pkg::KIND_BYTE;
      end
      lcdseq_pkg::CMD_CHAR: begin
        st.kind = lcdseq_pkg::KIND_BYTE;
        rs_next = 1'b1;
      end
      lcdseq_pkg::CMD_CLEAR: begin
        st.kind   = lcdseq_pkg::KIND_BYTE;
        byte_next = lcdseq_pkg::BYTE_CLEAR;
        long_next = 1'b1;
      end
      lcdseq_pkg::CMD_HOME: begin
        st.kind   = lcdseq_pkg::KIND_BYTE;
        byte_next = lcdseq_pkg::BYTE_HOME;
        long_next = 1'b1;
      end
      lcdseq_pkg::CMD_CURSOR: begin
        if (row == lcdseq_pkg::ROW_FIRST) begin
          st.kind   = lcdseq_pkg::KIND_BYTE;
          byte_next = addr | lcdseq_pkg::ROW1_BASE;
        end else if (row == lcdseq_pkg::ROW_SECOND) begin
          st.kind   = lcdseq_pkg::KIND_BYTE;
          byte_next = addr | lcdseq_pkg::ROW2_BASE;
        end
      end
      default: begin
        st.kind = lcdseq_pkg::KIND_NONE;
      end
    endcase
  end

  always_comb begin
    ent         = lcdseq_pkg::init_entry(cmd.step);
    strobe_next = 1'b1;
    rsel_next   = rs_q;
    nibble_next = byte_q[7:4];
    wait_next   = lcdseq_pkg::wait_value(lcdseq_pkg::WAIT_SETTLE);
    unique case (cmd.src)
      lcdseq_pkg::SRC_INIT: begin
        strobe_next = ent.strobe;
        rsel_next   = 1'b0;
        nibble_next = ent.nibble;
        wait_next   = lcdseq_pkg::wait_value(ent.wait_code);
      end
      lcdseq_pkg::SRC_HI: begin
        nibble_next = byte_q[7:4];
      end
      lcdseq_pkg::SRC_LO: begin
        nibble_next = byte_q[3:0];
        if (long_q) wait_next = lcdseq_pkg::wait_value(lcdseq_pkg::WAIT_LONG_CMD);
      end
      default: begin
        nibble_next = byte_q[7:4];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byte_q <= byte_next;
      rs_q   <= rs_next;
      long_q <= long_next;
    end
    if (cmd.load) begin
      strobe_res <= strobe_next;
      reg_select <= rsel_next;
      nibble     <= nibble_next;
      wait_us    <= wait_next;
      last       <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/lcdseq_ctrl.sv @@
// Controller: sequences init steps and high/low nibble writes.
module lcdseq_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  lcdseq_pkg::dp_status_t st,
  output lcdseq_pkg::ctrl_cmd_t  cmd
);

  lcdseq_pkg::state_t state, state_next;
  logic [lcdseq_pkg::StepW-1:0] step, step_next;
  logic accept;

  assign req_ready = (state == lcdseq_pkg::ST_IDLE);
  assign accept    = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcdseq_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      lcdseq_pkg::ST_IDLE: begin
        step_next = '0;
        if (accept) begin
          if (st.kind == lcdseq_pkg::KIND_INIT) state_next = lcdseq_pkg::ST_INIT;
          else if (st.kind == lcdseq_pkg::KIND_BYTE) state_next = lcdseq_pkg::ST_HI;
        end
      end
      lcdseq_pkg::ST_INIT: begin
        if (st.slot_free) begin
          if (step == lcdseq_pkg::INIT_LAST_STEP) begin
            state_next = lcdseq_pkg::ST_IDLE;
            step_next  = '0;
          end else begin
            step_next = step + 1'b1;
          end
        end
      end
      lcdseq_pkg::ST_HI: begin
        if (st.slot_free) state_next = lcdseq_pkg::ST_LO;
      end
      lcdseq_pkg::ST_LO: begin
        if (st.slot_free) state_next = lcdseq_pkg::ST_IDLE;
      end
      default: begin
        state_next = lcdseq_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd.capture = accept;
    cmd.load    = 1'b0;
    cmd.src     = lcdseq_pkg::SRC_INIT;
    cmd.step    = step;
    cmd.last    = 1'b0;
    unique case (state)
      lcdseq_pkg::ST_IDLE: begin
        cmd.load = 1'b0;
      end
      lcdseq_pkg::ST_INIT: begin
        cmd.load = st.slot_free;
        cmd.last = (step == lcdseq_pkg::INIT_LAST_STEP);
      end
      lcdseq_pkg::ST_HI: begin
        cmd.load = st.slot_free;
        cmd.src  = lcdseq_pkg::SRC_HI;
      end
      lcdseq_pkg::ST_LO: begin
        cmd.load = st.slot_free;
        cmd.src  = lcdseq_pkg::SRC_LO;
        cmd.last = 1'b1;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

  a_load_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> st.slot_free) else $error("load into an occupied result register");

  a_lo_is_last: assert property (@(posedge clk) disable iff (rst)
    (state == lcdseq_pkg::ST_LO && st.slot_free) |=> !req_ready || $past(cmd.last))
    else $error("low nibble not flagged last");

  a_init_ends: assert property (@(posedge clk) disable iff (rst)
    (state == lcdseq_pkg::ST_INIT && step == lcdseq_pkg::INIT_LAST_STEP && st.slot_free)
    |=> state == lcdseq_pkg::ST_IDLE) else $error("init did not end after last step");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == lcdseq_pkg::ST_INIT |-> step <= lcdseq_pkg::INIT_LAST_STEP)
    else $error("init step out of range");

endmodule

@@ rtl/char_lcd_nibble_sequencer_top.sv @@
// Top level of the character LCD 4-bit nibble sequencer.
// Each request transfer (command, value, row, column) becomes a run of
// nibble-write results for an HD44780-style display on a 4-bit bus; one
// result leaves per cycle while res_ready is high. A request yields 2
// results for byte-type commands and 13 for init. The controller's step
// counter walks the 13-entry power-up table for init; byte commands go out
// as high nibble then low nibble. The block handles one request at a time:
// req_ready is high only while the controller is idle. Set cursor with a
// row other than 1 or 2, and command codes 6 and 7, produce no results.
// last marks the final result of each request. wait_us is the settle time
// the display needs after that write.
module char_lcd_nibble_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [2:0]  command,
  input  logic [7:0]  value,
  input  logic [1:0]  row,
  input  logic [7:0]  column,
  output logic        res_valid,
  input  logic        res_ready,
  output logic        strobe_res,
  output logic        reg_select,
  output logic [3:0]  nibble,
  output logic [15:0] wait_us,
  output logic        last
);

  lcdseq_pkg::ctrl_cmd_t  cmd;
  lcdseq_pkg::dp_status_t st;

  // Controller: accepts requests, steps through the sequence.
  lcdseq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Datapath: decodes the request and holds the result register.
  lcdseq_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .command    (command),
    .value      (value),
    .row        (row),
    .column     (column),
    .cmd        (cmd),
    .st         (st),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .strobe_res (strobe_res),
    .reg_select (reg_select),
    .nibble     (nibble),
    .wait_us    (wait_us),
    .last       (last)
  );

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the character LCD nibble sequencer.
`timescale 1ns / 1ps

module tb_top;

  // Codes past the last defined command; the block must drop them silently.
  localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  localparam logic [1:0] ROW_NONE  = 2'd0;
  localparam logic [1:0] ROW_EXTRA = 2'd3;

  // Settle times after a nibble write, in microseconds.
  localparam logic [15:0] US_SETTLE  = 16'd100;
  localparam logic [15:0] US_LONG    = 16'd2100;
  localparam logic [15:0] US_POWERUP = 16'd40000;
  localparam logic [15:0] US_WAKE1   = 16'd5100;
  localparam logic [15:0] US_WAKE2   = 16'd250;

  // Power-up command bytes sent after the wake-up nibbles.
  localparam logic [7:0] FUNC_SET_4BIT = 8'h28;
  localparam logic [7:0] DISPLAY_ON    = 8'h0E;
  localparam logic [7:0] ENTRY_MODE    = 8'h06;

  localparam int RANDOM_ITEMS = 230;
  localparam int QUIET_ITEMS  = 40;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int TAIL_CYCLES  = 24;

  typedef struct {
    logic        strobe;
    logic        rs;
    logic [3:0]  nib;
    logic [15:0] settle_us;
    logic        is_last;
  } nib_write_t;

  // Expected nibble writes, oldest first; one request at a time.
  class nibble_scoreboard;
    nib_write_t pending[$];
    int errors;
    int checked;

    function void push_write(logic strobe, logic rs, logic [3:0] nib,
                             logic [15:0] settle_us);
      nib_write_t w;
      w.strobe    = strobe;
      w.rs        = rs;
      w.nib       = nib;
      w.settle_us = settle_us;
      w.is_last   = 1'b0;
      pending.push_back(w);
    endfunction

    // High nibble first; only the low nibble can carry a long settle.
    function void push_byte(logic rs, logic [7:0] data, logic [15:0] low_us);
      push_write(1'b1, rs, data[7:4], US_SETTLE);
      push_write(1'b1, rs, data[3:0], low_us);
    endfunction

    function void note_request(logic [2:0] cmd, logic [7:0] data,
                               logic [1:0] rw, logic [7:0] col);
      int prev_count;
      logic [7:0] addr;
      prev_count = pending.size();
      addr       = col - 8'd1;  // column 0 wraps to 255
      case (cmd)
        lcdseq_pkg::CMD_INIT: begin
          push_write(1'b0, 1'b0, 4'h0, US_POWERUP);
          push_write(1'b1, 1'b0, 4'h3, US_WAKE1);
          push_write(1'b1, 1'b0, 4'h3, US_WAKE2);
          push_write(1'b1, 1'b0, 4'h3, US_SETTLE);
          push_write(1'b1, 1'b0, 4'h2, US_SETTLE);
          push_byte(1'b0, FUNC_SET_4BIT, US_SETTLE);
          push_byte(1'b0, DISPLAY_ON, US_SETTLE);
          push_byte(1'b0, lcdseq_pkg::BYTE_CLEAR, US_LONG);
          push_byte(1'b0, ENTRY_MODE, US_SETTLE);
        end
        lcdseq_pkg::CMD_BYTE:  push_byte(1'b0, data, US_SETTLE);
        lcdseq_pkg::CMD_CHAR:  push_byte(1'b1, data, US_SETTLE);
        lcdseq_pkg::CMD_CLEAR: push_byte(1'b0, lcdseq_pkg::BYTE_CLEAR, US_LONG);
        lcdseq_pkg::CMD_HOME:  push_byte(1'b0, lcdseq_pkg::BYTE_HOME, US_LONG);
        lcdseq_pkg::CMD_CURSOR: begin
          if (rw == lcdseq_pkg::ROW_FIRST) begin
            push_byte(1'b0, addr | lcdseq_pkg::ROW1_BASE, US_SETTLE);
          end else if (rw == lcdseq_pkg::ROW_SECOND) begin
            push_byte(1'b0, addr | lcdseq_pkg::ROW2_BASE, US_SETTLE);
          end
        end
        default: ;
      endcase
      if (pending.size() > prev_count) pending[pending.size() - 1].is_last = 1'b1;
    endfunction

    function void check_write(logic strobe, logic rs, logic [3:0] nib,
                              logic [15:0] settle_us, logic is_last);
      nib_write_t w;
      if (pending.size() == 0) begin
        $error("unexpected nibble write: strobe %0b rs %0b nibble %0h wait %0d last %0b",
               strobe, rs, nib, settle_us, is_last);
        errors++;
        return;
      end
      w = pending.pop_front();
      checked++;
      if (strobe !== w.strobe) begin
        $error("strobe_res: expected %0b, got %0b", w.strobe, strobe);
        errors++;
      end
      if (rs !== w.rs) begin
        $error("reg_select: expected %0b, got %0b", w.rs, rs);
        errors++;
      end
      if (nib !== w.nib) begin
        $error("nibble: expected %0h, got %0h", w.nib, nib);
        errors++;
      end
      if (settle_us !== w.settle_us) begin
        $error("wait_us: expected %0d, got %0d", w.settle_us, settle_us);
        errors++;
      end
      if (is_last !== w.is_last) begin
        $error("last: expected %0b, got %0b", w.is_last, is_last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  logic [2:0]  command;
  logic [7:0]  value;
  logic [1:0]  row;
  logic [7:0]  column;
  logic        res_valid;
  logic        res_ready;
  logic        strobe_res;
  logic        reg_select;
  logic [3:0]  nibble;
  logic [15:0] wait_us;
  logic        last;

  nibble_scoreboard sb;
  bit quiet;       // set for the final stretch: no idling on either side
  int cycle_count;
  int n_req, n_init, n_cursor, n_ignored;

  char_lcd_nibble_sequencer_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .command    (command),
    .value      (value),
    .row        (row),
    .column     (column),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .strobe_res (strobe_res),
    .reg_select (reg_select),
    .nibble     (nibble),
    .wait_us    (wait_us),
    .last       (last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: every transfer goes straight to the scoreboard.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready)
      sb.check_write(strobe_res, reg_select, nibble, wait_us, last);
  end

  // Result side back-pressure: random stall bursts, none once quiet.
  initial begin
    int stall;
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        stall     = $urandom_range(1, 14);
        res_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ready = 1'b1;
    end
  end

  // Present one request and hold it until the block takes it. Valid is
  // left high so back-to-back requests never toggle it within a step.
  task automatic send_request(logic [2:0] cmd, logic [7:0] data,
                              logic [1:0] rw, logic [7:0] col);
    @(negedge clk);
    command   = cmd;
    value     = data;
    row       = rw;
    column    = col;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    sb.note_request(cmd, data, rw, col);
    n_req++;
    if (cmd == lcdseq_pkg::CMD_INIT) n_init++;
    if (cmd == lcdseq_pkg::CMD_CURSOR) n_cursor++;
    if (cmd == CMD_UNUSED_LO || cmd == CMD_UNUSED_HI ||
        (cmd == lcdseq_pkg::CMD_CURSOR && rw != lcdseq_pkg::ROW_FIRST &&
         rw != lcdseq_pkg::ROW_SECOND))
      n_ignored++;
  endtask

  task automatic idle_sender(int cycles);
    @(negedge clk);
    req_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Hold off new requests until every expected write has come out.
  task automatic drain_results();
    idle_sender(1);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    int useful;
    int pick;
    logic [2:0] cmd;
    logic [1:0] rw;

    sb        = new();
    quiet     = 1'b0;
    rst       = 1'b1;
    req_valid = 1'b0;
    command   = lcdseq_pkg::CMD_INIT;
    value     = 8'h00;
    row       = ROW_NONE;
    column    = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: every command, field extremes, column wrap, dropped rows
    // and unused codes, with back-to-back init and byte requests.
    send_request(lcdseq_pkg::CMD_INIT,   8'hFF, ROW_EXTRA,  8'hFF);
    send_request(lcdseq_pkg::CMD_INIT,   8'h00, ROW_NONE,   8'h00);
    send_request(lcdseq_pkg::CMD_BYTE,   8'h00, ROW_NONE,   8'h00);
    send_request(lcdseq_pkg::CMD_BYTE,   8'hFF, ROW_EXTRA,  8'hFF);
    send_request(lcdseq_pkg::CMD_CHAR,   8'hA5, lcdseq_pkg::ROW_FIRST,  8'h01);
    send_request(lcdseq_pkg::CMD_CHAR,   8'h5A, lcdseq_pkg::ROW_SECOND, 8'hFE);
    send_request(lcdseq_pkg::CMD_CLEAR,  8'hFF, ROW_EXTRA,  8'hFF);
    send_request(lcdseq_pkg::CMD_HOME,   8'hFF, ROW_EXTRA,  8'hFF);
    send_request(lcdseq_pkg::CMD_CURSOR, 8'h00, lcdseq_pkg::ROW_FIRST,  8'h01);
    send_request(lcdseq_pkg::CMD_CURSOR, 8'h00, lcdseq_pkg::ROW_SECOND, 8'h01);
    send_request(lcdseq_pkg::CMD_CURSOR, 8'hFF, lcdseq_pkg::ROW_FIRST,  8'h00);
    send_request(lcdseq_pkg::CMD_CURSOR, 8'hFF, lcdseq_pkg::ROW_SECOND, 8'h00);
    send_request(lcdseq_pkg::CMD_CURSOR, 8'h00, lcdseq_pkg::ROW_FIRST,  8'hFF);
    send_request(lcdseq_pkg::CMD_CURSOR, 8'h00, lcdseq_pkg::ROW_SECOND, 8'h41);
    send_request(lcdseq_pkg::CMD_CURSOR, 8'h00, ROW_NONE,   8'h05);
    send_request(lcdseq_pkg::CMD_BYTE,   8'h3C, ROW_NONE,   8'h00);
    send_request(lcdseq_pkg::CMD_CURSOR, 8'h00, ROW_EXTRA,  8'h05);
    send_request(CMD_UNUSED_LO, 8'hFF, lcdseq_pkg::ROW_FIRST,  8'h01);
    send_request(lcdseq_pkg::CMD_CHAR,   8'h80, ROW_NONE,   8'h00);
    send_request(CMD_UNUSED_HI, 8'h00, lcdseq_pkg::ROW_SECOND, 8'hFF);
    send_request(lcdseq_pkg::CMD_HOME,   8'h00, ROW_NONE,   8'h00);

    drain_results();

    // Random part; dropped requests do not count toward the total.
    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      if (useful == RANDOM_ITEMS / 2) drain_results();
      quiet = (useful >= RANDOM_ITEMS - QUIET_ITEMS);
      if (!quiet && $urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 14));

      pick = $urandom_range(0, 99);
      if (pick < 8)       cmd = lcdseq_pkg::CMD_INIT;
      else if (pick < 30) cmd = lcdseq_pkg::CMD_BYTE;
      else if (pick < 52) cmd = lcdseq_pkg::CMD_CHAR;
      else if (pick < 60) cmd = lcdseq_pkg::CMD_CLEAR;
      else if (pick < 68) cmd = lcdseq_pkg::CMD_HOME;
      else if (pick < 95) cmd = lcdseq_pkg::CMD_CURSOR;
      else if (pick < 98) cmd = CMD_UNUSED_LO;
      else                cmd = CMD_UNUSED_HI;

      // Cursor rows are mostly valid; the rest spread over all four.
      if ($urandom_range(0, 7) < 6)
        rw = $urandom_range(0, 1) ? lcdseq_pkg::ROW_SECOND : lcdseq_pkg::ROW_FIRST;
      else
        rw = 2'($urandom_range(0, 3));

      send_request(cmd, 8'($urandom_range(0, 255)), rw, 8'($urandom_range(0, 255)));
      if (!(cmd == CMD_UNUSED_LO || cmd == CMD_UNUSED_HI ||
            (cmd == lcdseq_pkg::CMD_CURSOR && rw != lcdseq_pkg::ROW_FIRST &&
             rw != lcdseq_pkg::ROW_SECOND)))
        useful++;
    end

    idle_sender(1);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d init, %0d set cursor, %0d dropped by design)",
             n_req, n_init, n_cursor, n_ignored);
    $display("Compared %0d nibble writes field by field, %0d mismatches",
             sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/lcdseq_pkg.sv
rtl/lcdseq_dp.sv
rtl/lcdseq_ctrl.sv
rtl/char_lcd_nibble_sequencer_top.sv
test/tb_top.sv
